/* hw/rtl/jhse_pkg.sv */
// ----------------------------------------------------------------------------
// jhse_pkg - shared types and tables of the JPEG Huffman symbol encoder
// Holds the standard Annex K bit counts and symbol lists, the canonical
// code builder and the word type that travels from front to back.
// ----------------------------------------------------------------------------
package jhse_pkg;

	typedef logic [7:0] bits_t [16];
	typedef logic [7:0] vals_t [162];
	typedef logic [20:0] code_tab_t [256];

	// Queue word: one classified symbol waiting for its code lookup
	typedef struct packed {
		logic [1:0]  bank;
		logic [7:0]  sym;
		logic        cat_ok;
		logic [10:0] extra;
		logic [3:0]  xlen;
		logic        eob;
	} sym_word_t;

	localparam logic [1:0] BANK_LUMA_DC   = 2'd0;
	localparam logic [1:0] BANK_CHROMA_DC = 2'd1;
	localparam logic [1:0] BANK_LUMA_AC   = 2'd2;
	localparam logic [1:0] BANK_CHROMA_AC = 2'd3;

	localparam logic [7:0] SYM_EOB = 8'h00;
	localparam logic [7:0] SYM_ZRL = 8'hF0;
	localparam logic [3:0] RUN_ZRL = 4'd15;
	localparam logic [3:0] MAX_DC_CAT = 4'd11;

	localparam bits_t LUMA_DC_BITS   = '{0,1,5,1,1,1,1,1,1,0,0,0,0,0,0,0};
	localparam bits_t CHROMA_DC_BITS = '{0,3,1,1,1,1,1,1,1,1,1,0,0,0,0,0};
	localparam bits_t LUMA_AC_BITS   = '{0,2,1,3,3,2,4,3,5,5,4,4,0,0,1,8'h7d};
	localparam bits_t CHROMA_AC_BITS = '{0,2,1,2,4,4,3,4,7,5,4,4,0,1,2,8'h77};

	localparam vals_t LUMA_AC_VALS = '{
		8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,8'h21,8'h31,8'h41,8'h06,
		8'h13,8'h51,8'h61,8'h07,8'h22,8'h71,8'h14,8'h32,8'h81,8'h91,8'ha1,8'h08,
		8'h23,8'h42,8'hb1,8'hc1,8'h15,8'h52,8'hd1,8'hf0,8'h24,8'h33,8'h62,8'h72,
		8'h82,8'h09,8'h0a,8'h16,8'h17,8'h18,8'h19,8'h1a,8'h25,8'h26,8'h27,8'h28,
		8'h29,8'h2a,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h3a,8'h43,8'h44,8'h45,
		8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,
		8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,8'h75,
		8'h76,8'h77,8'h78,8'h79,8'h7a,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,
		8'h8a,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,
		8'ha4,8'ha5,8'ha6,8'ha7,8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,
		8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,
		8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,8'hd9,8'hda,8'he1,8'he2,
		8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf1,8'hf2,8'hf3,8'hf4,
		8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa
	};

	localparam vals_t CHROMA_AC_VALS = '{
		8'h00,8'h01,8'h02,8'h03,8'h11,8'h04,8'h05,8'h21,8'h31,8'h06,8'h12,8'h41,
		8'h51,8'h07,8'h61,8'h71,8'h13,8'h22,8'h32,8'h81,8'h08,8'h14,8'h42,8'h91,
		8'ha1,8'hb1,8'hc1,8'h09,8'h23,8'h33,8'h52,8'hf0,8'h15,8'h62,8'h72,8'hd1,
		8'h0a,8'h16,8'h24,8'h34,8'he1,8'h25,8'hf1,8'h17,8'h18,8'h19,8'h1a,8'h26,
		8'h27,8'h28,8'h29,8'h2a,8'h35,8'h36,8'h37,8'h38,8'h39,8'h3a,8'h43,8'h44,
		8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,
		8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,
		8'h75,8'h76,8'h77,8'h78,8'h79,8'h7a,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,
		8'h88,8'h89,8'h8a,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,
		8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,
		8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,
		8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,8'hd9,8'hda,
		8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf2,8'hf3,8'hf4,
		8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa
	};

	// Build a canonical code bank: entry = {length, code}, length 0 = no code.
	// DC banks use the symbol index itself as the symbol.
	function automatic code_tab_t build_tab(input bits_t bits, input vals_t vals,
		input int nvals, input bit is_dc);
		code_tab_t tab;
		int code;
		int k;
		int sym;
		for (int e = 0; e < 256; e++) tab[e] = '0;
		code = 0;
		k = 0;
		for (int len = 1; len <= 16; len++) begin
			for (int i = 0; i < int'(bits[len-1]); i++) begin
				if (k < nvals) begin
					sym = is_dc ? k : int'(vals[k]);
					tab[sym] = {5'(len), 16'(code)};
					k++;
					code++;
				end
			end
			code = code << 1;
		end
		return tab;
	endfunction

	localparam code_tab_t LUMA_DC_TAB   = build_tab(LUMA_DC_BITS, LUMA_AC_VALS, 12, 1'b1);
	localparam code_tab_t CHROMA_DC_TAB = build_tab(CHROMA_DC_BITS, LUMA_AC_VALS, 12, 1'b1);
	localparam code_tab_t LUMA_AC_TAB   = build_tab(LUMA_AC_BITS, LUMA_AC_VALS, 162, 1'b0);
	localparam code_tab_t CHROMA_AC_TAB = build_tab(CHROMA_AC_BITS, CHROMA_AC_VALS, 162, 1'b0);

endpackage

/* hw/rtl/jhse_front.sv */
// ----------------------------------------------------------------------------
// jhse_front - symbol classifier
// Finds the category and magnitude bits, forms the table symbol, and drops
// AC words that follow an end of block until the next DC word.
// ----------------------------------------------------------------------------
module jhse_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic                operation,
	input  logic                is_chroma,
	input  logic [3:0]          zero_run,
	input  logic signed [11:0]  coeff_value,
	output logic                push,
	output jhse_pkg::sym_word_t push_word
);

	logic        skip_q;
	logic        neg;
	logic [11:0] raw;
	logic [11:0] mag;
	logic [3:0]  cat;
	logic [11:0] mask;
	logic        is_eob;
	logic        accept;

	assign raw    = coeff_value;
	assign neg    = raw[11];
	assign mag    = neg ? (12'd0 - raw) : raw;
	assign accept = in_valid && in_ready;

	// Category: position of the leading one of the magnitude
	always_comb begin
		cat = 4'd0;
		for (int b = 0; b < 12; b++) begin
			if (mag[b]) cat = 4'(b + 1);
		end
	end

	assign mask   = 12'((13'd1 << cat) - 13'd1);
	assign is_eob = operation && (raw == 12'd0) && (zero_run == 4'd0);

	// Form the queue word
	always_comb begin
		logic [11:0] ext;
		ext = neg ? ((raw - 12'd1) & mask) : raw;
		push_word.bank   = {operation, is_chroma};
		push_word.cat_ok = (cat <= jhse_pkg::MAX_DC_CAT);
		push_word.extra  = ext[10:0];
		push_word.xlen   = cat;
		push_word.eob    = is_eob;
		if (!operation) push_word.sym = {4'd0, cat};
		else if (is_eob) push_word.sym = jhse_pkg::SYM_EOB;
		else if (raw == 12'd0 && zero_run == jhse_pkg::RUN_ZRL) push_word.sym = jhse_pkg::SYM_ZRL;
		else push_word.sym = {zero_run, cat};
	end

	assign push = accept && !(operation && skip_q);

	// Track the skip state: EOB always has a code, so it always arms the skip
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= 1'b0;
		end else if (accept) begin
			if (!operation) skip_q <= 1'b0;
			else if (is_eob) skip_q <= 1'b1;
		end
	end

endmodule

/* hw/rtl/jhse_queue.sv */
// ----------------------------------------------------------------------------
// jhse_queue - two-word queue between front and back
// Lets the front keep accepting while the back waits on the output side.
// ----------------------------------------------------------------------------
module jhse_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  jhse_pkg::sym_word_t push_word,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output jhse_pkg::sym_word_t pop_word
);

	jhse_pkg::sym_word_t slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_word  = slot_q[rd_q];

	// Store the incoming word
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_word;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

/* hw/rtl/jhse_back.sv */
// ----------------------------------------------------------------------------
// jhse_back - code lookup and output register
// Reads the canonical code bank for each queued word and holds the result
// word until the sink takes it.
// ----------------------------------------------------------------------------
module jhse_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                not_empty,
	input  jhse_pkg::sym_word_t word,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [15:0]         huff_code,
	output logic [4:0]          huff_length,
	output logic [10:0]         extra_bits,
	output logic [3:0]          extra_length,
	output logic                is_end_of_block,
	output logic                bad_symbol
);

	logic        valid_q;
	logic [20:0] entry;
	logic        bad;

	// Select the bank and read the symbol
	always_comb begin
		case (word.bank)
			jhse_pkg::BANK_LUMA_DC:   entry = jhse_pkg::LUMA_DC_TAB[word.sym];
			jhse_pkg::BANK_CHROMA_DC: entry = jhse_pkg::CHROMA_DC_TAB[word.sym];
			jhse_pkg::BANK_LUMA_AC:   entry = jhse_pkg::LUMA_AC_TAB[word.sym];
			jhse_pkg::BANK_CHROMA_AC: entry = jhse_pkg::CHROMA_AC_TAB[word.sym];
			default:                  entry = '0;
		endcase
		if (!word.cat_ok) entry = '0;
	end

	assign bad       = (entry[20:16] == 5'd0);
	assign pop       = not_empty && (!valid_q || out_ready);
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Load the result word; an unknown symbol clears every field but the flag
	always_ff @(posedge clk) begin
		if (pop) begin
			huff_code       <= bad ? 16'd0 : entry[15:0];
			huff_length     <= entry[20:16];
			extra_bits      <= bad ? 11'd0 : word.extra;
			extra_length    <= bad ? 4'd0 : word.xlen;
			is_end_of_block <= bad ? 1'b0 : word.eob;
			bad_symbol      <= bad;
		end
	end

endmodule

/* hw/rtl/jpeg_huffman_symbol_encoder_top.sv */
// An accepted input word is written into a queue slot and then loaded into the output register.
// Throughput: one word per cycle while the sink is ready; the code lookup is a constant table read.
// A two-word queue parts classifier and lookup so either side can stall.
// AC words after an end of block give no result until the next DC word.
// Reset (arst_n low, asynchronous) empties queue and output, clears skip state.
// ----------------------------------------------------------------------------
// jpeg_huffman_symbol_encoder_top - JPEG baseline Huffman symbol encoder
// Gives the standard code, magnitude bits and category for each symbol.
// ----------------------------------------------------------------------------
module jpeg_huffman_symbol_encoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // zero_run[3:0], coeff_value[15:4]
	input  logic [1:0]  s_axis_tuser,  // operation[0], is_chroma[1]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // huff_code[15:0], huff_length[20:16],
	                                   // extra_bits[31:21], extra_length[35:32]
	output logic        m_axis_tlast,  // is_end_of_block
	output logic        m_axis_tuser   // bad_symbol
);

	logic                full;
	logic                push;
	logic                pop;
	logic                not_empty;
	jhse_pkg::sym_word_t push_word;
	jhse_pkg::sym_word_t pop_word;
	logic [15:0]         huff_code;
	logic [4:0]          huff_length;
	logic [10:0]         extra_bits;
	logic [3:0]          extra_length;

	assign s_axis_tready = !full;

	jhse_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.operation   (s_axis_tuser[0]),
		.is_chroma   (s_axis_tuser[1]),
		.zero_run    (s_axis_tdata[3:0]),
		.coeff_value (s_axis_tdata[15:4]),
		.push        (push),
		.push_word   (push_word)
	);

	jhse_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_word  (pop_word)
	);

	jhse_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.not_empty       (not_empty),
		.word            (pop_word),
		.pop             (pop),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.huff_code       (huff_code),
		.huff_length     (huff_length),
		.extra_bits      (extra_bits),
		.extra_length    (extra_length),
		.is_end_of_block (m_axis_tlast),
		.bad_symbol      (m_axis_tuser)
	);

	assign m_axis_tdata = {4'd0, extra_length, extra_bits, huff_length, huff_code};

endmodule
